>>> hdl/npls_pkg.sv
// ----------------------------------------------------------------------------
// npls_pkg
// shared types and defaults of the nearest point linear search unit
// ----------------------------------------------------------------------------
package npls_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_COORD_BITS = 16;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PUT  = 3'b100
    } t_state;

endpackage

>>> hdl/npls_ram.sv
// ----------------------------------------------------------------------------
// npls_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module npls_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/npls_dist.sv
// ----------------------------------------------------------------------------
// npls_dist
// two stage squared distance pipeline: squares, then their sum
// ----------------------------------------------------------------------------
module npls_dist #(
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 10,
    parameter int DIST_W     = 2 * COORD_BITS + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [IDX_W-1:0]        i_index,
    input  logic [3*COORD_BITS-1:0] i_point,
    input  logic [3*COORD_BITS-1:0] i_query,
    output logic                    o_valid,
    output logic                    o_busy,
    output logic [IDX_W-1:0]        o_index,
    output logic [3*COORD_BITS-1:0] o_point,
    output logic [DIST_W-1:0]       o_dist
);

    localparam int C  = COORD_BITS;
    localparam int SW = 2 * C;

    logic signed [C:0]      dx, dy, dz;
    logic signed [2*C+1:0]  px, py, pz;

    logic                   r_v1, r_v2;
    logic [IDX_W-1:0]       r_idx1, r_idx2;
    logic [3*C-1:0]         r_pt1, r_pt2;
    logic [SW-1:0]          r_sqx, r_sqy, r_sqz;
    logic [DIST_W-1:0]      r_dist;

    // differences are exact with one extra bit
    assign dx = $signed({i_point[3*C-1], i_point[3*C-1:2*C]})
              - $signed({i_query[3*C-1], i_query[3*C-1:2*C]});
    assign dy = $signed({i_point[2*C-1], i_point[2*C-1:C]})
              - $signed({i_query[2*C-1], i_query[2*C-1:C]});
    assign dz = $signed({i_point[C-1], i_point[C-1:0]})
              - $signed({i_query[C-1], i_query[C-1:0]});

    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_idx1 <= i_index;
        r_pt1  <= i_point;
        // a square of a difference never needs more than 2C bits
        r_sqx  <= px[SW-1:0];
        r_sqy  <= py[SW-1:0];
        r_sqz  <= pz[SW-1:0];
        r_idx2 <= r_idx1;
        r_pt2  <= r_pt1;
        r_dist <= DIST_W'(r_sqx) + DIST_W'(r_sqy) + DIST_W'(r_sqz);
    end

    assign o_valid = r_v2;
    assign o_busy  = r_v1 | r_v2;
    assign o_index = r_idx2;
    assign o_point = r_pt2;
    assign o_dist  = r_dist;

endmodule

>>> hdl/nearest_point_linear_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_linear_search_unit
// brute force nearest neighbor search over a store of 3d points
// ----------------------------------------------------------------------------
// A load request appends a point to the point memory and gives no result; a
// load into a full store gives a result with status full. A clear request
// empties the store. A query request reads every stored point, one per cycle
// through the single read port of the point memory; each read point passes
// the square stage and the sum stage to the compare, and once the pipeline
// is seen empty the best point is loaded into the output register and
// offered as the result. Ties go to the lowest index. A query on an empty
// store gives status empty. Only stored points are read, so the memory needs
// no clearing pass after reset. One request is in work at a time; a waiting
// result does not hold off the next request, but one that has a result too
// then waits with it until the output is free, taking no new request.
// ----------------------------------------------------------------------------
module nearest_point_linear_search_unit #(
    parameter int MAX_POINTS = npls_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = npls_pkg::DEF_COORD_BITS,
    parameter int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    parameter int DIST_W     = 2 * COORD_BITS + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_action,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [IDX_W-1:0]             o_best_index,
    output logic [DIST_W-1:0]            o_best_dist_sq,
    output logic signed [COORD_BITS-1:0] o_near_x,
    output logic signed [COORD_BITS-1:0] o_near_y,
    output logic signed [COORD_BITS-1:0] o_near_z,
    output npls_pkg::t_status            o_status
);

    import npls_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int PW    = 3 * C;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic [PW-1:0]      r_query, n_query;
    logic               r_v1;
    logic [IDX_W-1:0]   r_idx1;

    logic               r_have, n_have;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    logic [DIST_W-1:0]  r_best_dist, n_best_dist;
    logic [PW-1:0]      r_best_pt, n_best_pt;
    t_status            r_res_status, n_res_status;

    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic [DIST_W-1:0]  r_out_dist;
    logic [PW-1:0]      r_out_pt;
    t_status            r_out_status;

    logic               accept;
    logic               issue;
    logic               mem_we;
    logic [PW-1:0]      mem_rdata;
    logic               out_free;
    logic               put_now;

    logic               c_valid, c_busy;
    logic [IDX_W-1:0]   c_index;
    logic [PW-1:0]      c_point;
    logic [DIST_W-1:0]  c_dist;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign issue      = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign mem_we     = accept && (i_action == ACT_LOAD)
                     && (r_count != CNT_W'(MAX_POINTS));
    assign out_free   = ~r_out_valid | i_out_ready;
    assign put_now    = (r_state == S_PUT) && out_free;

    npls_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_coord_x, i_coord_y, i_coord_z}),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    npls_dist #(
        .COORD_BITS (C),
        .IDX_W      (IDX_W),
        .DIST_W     (DIST_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_index (r_idx1),
        .i_point (mem_rdata),
        .i_query (r_query),
        .o_valid (c_valid),
        .o_busy  (c_busy),
        .o_index (c_index),
        .o_point (c_point),
        .o_dist  (c_dist)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_query      = r_query;
        n_have       = r_have;
        n_best_idx   = r_best_idx;
        n_best_dist  = r_best_dist;
        n_best_pt    = r_best_pt;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid & ~i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_LOAD: begin
                            if (r_count == CNT_W'(MAX_POINTS)) begin
                                n_best_idx   = '0;
                                n_best_dist  = '0;
                                n_best_pt    = '0;
                                n_res_status = ST_FULL;
                                n_state      = S_PUT;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        ACT_QUERY: begin
                            n_query  = {i_coord_x, i_coord_y, i_coord_z};
                            n_rd_idx = '0;
                            n_have   = 1'b0;
                            if (r_count == '0) begin
                                n_best_idx   = '0;
                                n_best_dist  = '0;
                                n_best_pt    = '0;
                                n_res_status = ST_EMPTY;
                                n_state      = S_PUT;
                            end else begin
                                n_res_status = ST_OK;
                                n_state      = S_SCAN;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                // strict compare keeps the lowest index on a tie
                if (c_valid && (!r_have || (c_dist < r_best_dist))) begin
                    n_have      = 1'b1;
                    n_best_idx  = c_index;
                    n_best_dist = c_dist;
                    n_best_pt   = c_point;
                end
                if (!issue && !r_v1 && !c_busy) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_v1        <= issue;
            r_out_valid <= n_out_valid;
            r_have      <= n_have;
        end
        r_rd_idx     <= n_rd_idx;
        r_query      <= n_query;
        r_idx1       <= r_rd_idx[IDX_W-1:0];
        r_best_idx   <= n_best_idx;
        r_best_dist  <= n_best_dist;
        r_best_pt    <= n_best_pt;
        r_res_status <= n_res_status;
        if (put_now) begin
            r_out_idx    <= r_best_idx;
            r_out_dist   <= r_best_dist;
            r_out_pt     <= r_best_pt;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_best_index   = r_out_idx;
    assign o_best_dist_sq = r_out_dist;
    assign o_near_x       = $signed(r_out_pt[3*C-1:2*C]);
    assign o_near_y       = $signed(r_out_pt[2*C-1:C]);
    assign o_near_z       = $signed(r_out_pt[C-1:0]);
    assign o_status       = r_out_status;

endmodule

>>> tb/npls_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// npls_result_checker
// watches the request and result channels of the nearest point search unit,
// keeps its own copy of the point store, predicts the result of every
// accepted request that has one, compares each accepted result field by field
// ----------------------------------------------------------------------------
module npls_result_checker #(
    parameter int MAX_POINTS = npls_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = npls_pkg::DEF_COORD_BITS,
    parameter int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    parameter int DIST_W     = 2 * COORD_BITS + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [1:0]                   i_action,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [IDX_W-1:0]             i_best_index,
    input  logic [DIST_W-1:0]            i_best_dist_sq,
    input  logic signed [COORD_BITS-1:0] i_near_x,
    input  logic signed [COORD_BITS-1:0] i_near_y,
    input  logic signed [COORD_BITS-1:0] i_near_z,
    input  npls_pkg::t_status            i_status,
    output int                           o_fail_count,
    output int                           o_pending
);

    import npls_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]             best_index;
        logic [DIST_W-1:0]            best_dist_sq;
        logic signed [COORD_BITS-1:0] near_x;
        logic signed [COORD_BITS-1:0] near_y;
        logic signed [COORD_BITS-1:0] near_z;
        t_status                      status;
    } t_nearest;

    t_nearest expected_q[$];
    t_nearest oldest;

    logic signed [COORD_BITS-1:0] store_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] store_y [MAX_POINTS];
    logic signed [COORD_BITS-1:0] store_z [MAX_POINTS];
    int stored = 0;
    int mismatches = 0;
    int waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function automatic t_nearest flagged(input t_status st);
        t_nearest r;
        r.best_index   = '0;
        r.best_dist_sq = '0;
        r.near_x       = '0;
        r.near_y       = '0;
        r.near_z       = '0;
        r.status       = st;
        return r;
    endfunction

    function automatic void predict_request(input logic [1:0] act,
                                            input logic signed [COORD_BITS-1:0] qx,
                                            input logic signed [COORD_BITS-1:0] qy,
                                            input logic signed [COORD_BITS-1:0] qz);
        t_nearest r;
        longint   dx;
        longint   dy;
        longint   dz;
        longint   d;
        longint   best_d;
        int       best;
        r = flagged(ST_OK);
        case (act)
            ACT_LOAD: begin
                if (stored >= MAX_POINTS) begin
                    expected_q.push_back(flagged(ST_FULL));
                end else begin
                    store_x[stored] = qx;
                    store_y[stored] = qy;
                    store_z[stored] = qz;
                    stored++;
                end
            end
            ACT_QUERY: begin
                if (stored == 0) begin
                    expected_q.push_back(flagged(ST_EMPTY));
                end else begin
                    best   = 0;
                    best_d = -1;
                    for (int i = 0; i < stored; i++) begin
                        dx = longint'(store_x[i]) - longint'(qx);
                        dy = longint'(store_y[i]) - longint'(qy);
                        dz = longint'(store_z[i]) - longint'(qz);
                        d  = dx * dx + dy * dy + dz * dz;
                        // strict compare keeps the lowest index on a tie
                        if (best_d < 0 || d < best_d) begin
                            best_d = d;
                            best   = i;
                        end
                    end
                    r.best_index   = best[IDX_W-1:0];
                    r.best_dist_sq = best_d[DIST_W-1:0];
                    r.near_x       = store_x[best];
                    r.near_y       = store_y[best];
                    r.near_z       = store_z[best];
                    expected_q.push_back(r);
                end
            end
            ACT_CLEAR: begin
                stored = 0;
            end
            default: begin
                // unused action code changes nothing
            end
        endcase
    endfunction

    function automatic void compare_field(input string name,
                                          input logic signed [63:0] exp_v,
                                          input logic signed [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored = 0;
            expected_q.delete();
        end else begin
            // results first: a request can not be answered in its own cycle
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result accepted with no request waiting for one");
                    mismatches++;
                end else begin
                    oldest = expected_q.pop_front();
                    compare_field("best_index", oldest.best_index, i_best_index);
                    compare_field("best_dist_sq", oldest.best_dist_sq, i_best_dist_sq);
                    compare_field("near_x", oldest.near_x, i_near_x);
                    compare_field("near_y", oldest.near_y, i_near_y);
                    compare_field("near_z", oldest.near_z, i_near_z);
                    compare_field("status", oldest.status, i_status);
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_request(i_action, i_coord_x, i_coord_y, i_coord_z);
            end
        end
        waiting = expected_q.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the nearest point linear search unit
// ----------------------------------------------------------------------------
// Directed requests cover the empty store, extreme coordinates, the largest
// distance, ties and the unused action code. A fill phase loads a few hundred
// points and queries the large store. Random rounds then clear, load small
// clusters of points and query near them, with random idling on both
// channels. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

    import npls_pkg::*;

    localparam int MAX_POINTS     = DEF_MAX_POINTS;
    localparam int COORD_BITS     = DEF_COORD_BITS;
    localparam int IDX_W          = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DIST_W         = 2 * COORD_BITS + 2;
    localparam logic [1:0] ACT_NONE = 2'd3;  // unused code, ignored by the unit
    localparam int FILL_POINTS    = 200;
    localparam int RANDOM_REQS    = 340;
    localparam int IDLE_PCT       = 37;
    localparam int DRAIN_CYCLES   = MAX_POINTS + 16;
    localparam int WATCHDOG_LIMIT = 8 * MAX_POINTS + 1000;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    localparam t_coord C_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord C_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam t_coord C_ZERO = '0;
    localparam t_coord C_ONE  = 1;
    localparam t_coord C_NEG1 = -1;

    bit                   clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           in_action;
    t_coord               in_x;
    t_coord               in_y;
    t_coord               in_z;
    logic                 out_valid;
    logic                 out_ready;
    logic [IDX_W-1:0]     best_index;
    logic [DIST_W-1:0]    best_dist_sq;
    t_coord               near_x;
    t_coord               near_y;
    t_coord               near_z;
    t_status              status;
    int                   fail_count;
    int                   pending;

    bit                   idle_en;
    t_point               loaded[$];

    nearest_point_linear_search_unit #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_action       (in_action),
        .i_coord_x      (in_x),
        .i_coord_y      (in_y),
        .i_coord_z      (in_z),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_best_index   (best_index),
        .o_best_dist_sq (best_dist_sq),
        .o_near_x       (near_x),
        .o_near_y       (near_y),
        .o_near_z       (near_z),
        .o_status       (status)
    );

    npls_result_checker #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_action       (in_action),
        .i_coord_x      (in_x),
        .i_coord_y      (in_y),
        .i_coord_z      (in_z),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_best_index   (best_index),
        .i_best_dist_sq (best_dist_sq),
        .i_near_x       (near_x),
        .i_near_y       (near_y),
        .i_near_z       (near_z),
        .i_status       (status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(negedge clk) begin
        out_ready <= !idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0: return C_MIN;
            1: return C_MAX;
            default: return t_coord'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_point rand_point();
        t_point p;
        p.x = rand_coord();
        p.y = rand_coord();
        p.z = rand_coord();
        return p;
    endfunction

    // small offset around a point, wrapping at the coordinate range
    function automatic t_point nudge(input t_point p);
        t_point n;
        n.x = p.x + t_coord'($urandom_range(0, 8)) - t_coord'(4);
        n.y = p.y + t_coord'($urandom_range(0, 8)) - t_coord'(4);
        n.z = p.z + t_coord'($urandom_range(0, 8)) - t_coord'(4);
        return n;
    endfunction

    task automatic send_req(input logic [1:0] act, input t_coord x, input t_coord y,
                            input t_coord z);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_x      <= x;
        in_y      <= y;
        in_z      <= z;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_point(input t_point p);
        send_req(ACT_LOAD, p.x, p.y, p.z);
        loaded.push_back(p);
    endtask

    task automatic query_point(input t_point p);
        send_req(ACT_QUERY, p.x, p.y, p.z);
    endtask

    task automatic clear_store();
        t_point p;
        p = rand_point();
        send_req(ACT_CLEAR, p.x, p.y, p.z);
        loaded.delete();
    endtask

    // hold off new requests until every predicted result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        t_point p;
        t_point base;
        int     random_reqs;
        int     n_loads;
        int     n_queries;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_action <= ACT_LOAD;
        in_x      <= '0;
        in_y      <= '0;
        in_z      <= '0;
        idle_en   = 1'b1;
        random_reqs = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners, ties and the empty store
        send_req(ACT_QUERY, C_MIN, C_MAX, C_ZERO);
        send_req(ACT_NONE, C_MAX, C_MAX, C_MAX);
        send_req(ACT_LOAD, C_MAX, C_MAX, C_MAX);
        send_req(ACT_QUERY, C_MIN, C_MIN, C_MIN);
        send_req(ACT_LOAD, C_MAX, C_MAX, C_MAX);
        send_req(ACT_QUERY, C_MAX, C_MAX, C_MAX);
        send_req(ACT_LOAD, C_MIN, C_MIN, C_MIN);
        send_req(ACT_QUERY, C_MIN, C_MIN, C_MIN);
        send_req(ACT_QUERY, C_ZERO, C_ZERO, C_ZERO);
        send_req(ACT_LOAD, C_ZERO, C_ZERO, C_NEG1);
        send_req(ACT_LOAD, C_ZERO, C_ZERO, C_ONE);
        send_req(ACT_QUERY, C_ZERO, C_ZERO, C_ZERO);
        send_req(ACT_QUERY, C_MAX, C_MIN, C_ZERO);
        send_req(ACT_CLEAR, C_MIN, C_MAX, C_NEG1);
        send_req(ACT_QUERY, C_ONE, C_NEG1, C_ZERO);
        send_req(ACT_LOAD, C_NEG1, C_NEG1, C_NEG1);
        send_req(ACT_QUERY, C_MIN, C_MAX, C_MIN);
        send_req(ACT_CLEAR, C_ZERO, C_ZERO, C_ZERO);
        wait_drained();

        // fill a large store, then scan it
        clear_store();
        repeat (FILL_POINTS) begin
            if (loaded.size() != 0 && $urandom_range(0, 31) == 0) begin
                load_point(loaded[$urandom_range(0, loaded.size() - 1)]);
            end else begin
                load_point(rand_point());
            end
        end
        query_point(loaded[FILL_POINTS-1]);
        query_point(loaded[0]);
        query_point(nudge(loaded[$urandom_range(0, FILL_POINTS - 1)]));
        query_point(rand_point());
        clear_store();

        // random rounds of clustered loads and nearby queries
        while (random_reqs < RANDOM_REQS) begin
            idle_en = !(random_reqs >= 150 && random_reqs < 270);
            if ($urandom_range(0, 9) == 0) begin
                p = rand_point();
                send_req(ACT_NONE, p.x, p.y, p.z);
            end
            if ($urandom_range(0, 4) != 0) begin
                clear_store();
                random_reqs++;
            end
            n_loads = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
            base = rand_point();
            repeat (n_loads) begin
                case ($urandom_range(0, 4))
                    0, 1: p = rand_point();
                    2, 3: p = nudge(base);
                    default: begin
                        p = (loaded.size() != 0) ?
                            loaded[$urandom_range(0, loaded.size() - 1)] : base;
                    end
                endcase
                load_point(p);
                random_reqs++;
            end
            n_queries = $urandom_range(1, 6);
            repeat (n_queries) begin
                if ($urandom_range(0, 19) == 0) begin
                    wait_drained();
                end
                if ($urandom_range(0, 14) == 0) begin
                    p = rand_point();
                    send_req(ACT_NONE, p.x, p.y, p.z);
                end
                if (loaded.size() == 0 || $urandom_range(0, 3) == 0) begin
                    p = rand_point();
                end else begin
                    p = loaded[$urandom_range(0, loaded.size() - 1)];
                    if ($urandom_range(0, 2) != 0) begin
                        p = nudge(p);
                    end
                end
                query_point(p);
                random_reqs++;
            end
        end

        idle_en = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
